// ===== src/escu_pkg.sv =====
// ----------------------------------------------------------------------------
// escu_pkg: shared types and constants
// Step-size controller types, sequencer states and log-domain constants.
// ----------------------------------------------------------------------------
package escu_pkg;

  // fraction bits of the base-2 log domain
  localparam int unsigned LogFrac = 24;
  localparam int unsigned LogW    = 32;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_CUR = 3'd0,
    REG_GAIN_RAT = 3'd1,
    REG_BIAS     = 3'd2,
    REG_SAFETY   = 3'd3,
    REG_ORDER    = 3'd4
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BLO,
    ST_BHI,
    ST_BFIN,
    ST_LLOAD,
    ST_LNORM,
    ST_LSQ,
    ST_LSQR,
    ST_LEND,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_DIV,
    ST_ESET,
    ST_SQLOAD,
    ST_SQRT,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] gain_cur;
    logic [31:0] gain_rat;
    logic [31:0] bias;
    logic [31:0] safety;
    logic [3:0]  order;
  } cfg_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    logic        record;
    logic [63:0] value;
    logic        sat;
    logic [63:0] ecur;
  } res_t;

endpackage

// ===== src/escu_mul.sv =====
// ----------------------------------------------------------------------------
// escu_mul: shared multiplier
// 33x33 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module escu_mul (
  input  logic        clk_i,
  input  logic [32:0] a_i,
  input  logic [32:0] b_i,
  output logic [65:0] p_o
);

  logic [65:0] p_q;

  // product register, read in the cycle after the operands are driven
  always_ff @(posedge clk_i) begin
    p_q <= 66'(a_i) * 66'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== src/escu_core.sv =====
// ----------------------------------------------------------------------------
// escu_core: step-size sequencer
// Biased error, log2, gain products, order division and exp2 on one datapath.
// ----------------------------------------------------------------------------
module escu_core #(
  parameter int unsigned DATA_FRAC_BITS = 40,
  parameter int unsigned GAIN_FRAC_BITS = 28,
  parameter int unsigned TINY_FLOOR     = 110
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               action_i,
  input  logic [63:0]        step_size_i,
  input  logic [63:0]        error_norm_i,
  input  logic [63:0]        prev_error_i,
  input  logic               first_step_i,
  input  escu_pkg::cfg_t     cfg_i,
  input  logic               ack_i,
  output escu_pkg::res_t     res_o
);

  localparam logic [63:0] Tiny = 64'(TINY_FLOOR);
  localparam logic [31:0] DOff = 32'(DATA_FRAC_BITS) << escu_pkg::LogFrac;
  localparam logic [63:0] GOff = 64'(GAIN_FRAC_BITS) << escu_pkg::LogFrac;

  escu_pkg::state_e state_q, state_d;

  logic [5:0]  cnt_q, cnt_d;
  logic [4:0]  it_q, it_d;
  logic [1:0]  lsel_q, lsel_d;
  logic        act_q, act_d, first_q, first_d;
  logic [63:0] h_q, h_d, dsm_q, dsm_d, prev_q, prev_d, ecur_q, ecur_d, lo_q, lo_d;
  logic [63:0] x_q, x_d;
  logic [5:0]  n_q, n_d;
  logic [31:0] y_q, y_d;
  logic [23:0] frac_q, frac_d;
  logic signed [31:0] l1_q, l1_d, lp_q, lp_d, lh_q, lh_d, ls_q, ls_d;
  logic signed [63:0] g_q, g_d;
  logic [63:0] dv_q, dv_d;
  logic [3:0]  rem_q, rem_d;
  logic        neg_q, neg_d;
  logic signed [39:0] qi_q, qi_d;
  logic [63:0] sx_q, sx_d, sres_q, sres_d, sbit_q, sbit_d;
  logic [63:0] rv_q, rv_d;
  logic        sat_q, sat_d;

  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic [3:0]  order;

  escu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign order = (cfg_i.order == 4'd0) ? 4'd1 : cfg_i.order;

  // magnitudes fed to the gain products
  logic [31:0]        mag1, mag2;
  logic signed [32:0] diff;
  always_comb begin
    diff = {l1_q[31], l1_q} - {lp_q[31], lp_q};
    mag1 = l1_q[31] ? 32'(-l1_q) : 32'(l1_q);
    mag2 = diff[32] ? 32'(-diff) : 32'(diff);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      escu_pkg::ST_BLO: begin
        mul_a = {1'b0, dsm_q[31:0]};
        mul_b = {1'b0, cfg_i.bias};
      end
      escu_pkg::ST_BHI: begin
        mul_a = {1'b0, dsm_q[63:32]};
        mul_b = {1'b0, cfg_i.bias};
      end
      escu_pkg::ST_LSQ: begin
        mul_a = {1'b0, y_q};
        mul_b = {1'b0, y_q};
      end
      escu_pkg::ST_G1: begin
        mul_a = {1'b0, mag1};
        mul_b = {1'b0, cfg_i.gain_cur};
      end
      escu_pkg::ST_G2: begin
        mul_a = {1'b0, mag2};
        mul_b = {1'b0, cfg_i.gain_rat};
      end
      default: ;
    endcase
  end

  // biased error from the two partial products
  logic [63:0] hi, u, bias_val;
  logic [64:0] bsum;
  always_comb begin
    hi   = mul_p[63:0];
    u    = hi << (32 - GAIN_FRAC_BITS);
    bsum = {1'b0, u} + {1'b0, lo_q >> GAIN_FRAC_BITS};
    if (((hi >> (32 + GAIN_FRAC_BITS)) != 64'd0) || bsum[64]) bias_val = '1;
    else bias_val = bsum[63:0];
  end

  // log operand
  logic [63:0] lop;
  always_comb begin
    case (lsel_q)
      2'd0:    lop = (ecur_q > Tiny) ? ecur_q : Tiny;
      2'd1:    lop = (prev_q > Tiny) ? prev_q : Tiny;
      2'd2:    lop = h_q;
      default: lop = {32'd0, cfg_i.safety};
    endcase
  end

  // normalize step
  logic [6:0]  sh;
  logic [63:0] x_nrm;
  logic [5:0]  n_nrm;
  always_comb begin
    sh = 7'd32 >> cnt_q;
    if ((x_q >> (7'd64 - sh)) == 64'd0) begin
      x_nrm = x_q << sh;
      n_nrm = n_q - sh[5:0];
    end else begin
      x_nrm = x_q;
      n_nrm = n_q;
    end
  end

  // gain product scaling and the signed sum
  logic [65:0]        gsh;
  logic signed [63:0] gs, gsum;
  logic signed [31:0] lv;
  always_comb begin
    gsh  = mul_p >> GAIN_FRAC_BITS;
    gs   = (state_q == escu_pkg::ST_G2) ?
           (l1_q[31] ? -$signed(gsh[63:0]) : $signed(gsh[63:0])) :
           (diff[32] ? -$signed(gsh[63:0]) : $signed(gsh[63:0]));
    gsum = g_q + gs;
    lv   = $signed({2'b00, n_q, frac_q});
  end

  // division step
  logic [4:0] r5;
  logic       qbit;
  always_comb begin
    r5   = {rem_q, dv_q[63]};
    qbit = (r5 >= {1'b0, order});
  end

  // exponent sum
  logic signed [63:0] xq, esum;
  always_comb begin
    xq   = neg_q ? -$signed(dv_q) : $signed(dv_q);
    esum = 64'(lh_q) + 64'(ls_q) - $signed(GOff) + xq;
  end

  // square-root step
  logic [63:0] st;
  logic        sge;
  logic [32:0] sv;
  always_comb begin
    st  = sres_q + sbit_q;
    sge = (sx_q >= st);
    sv  = frac_q[it_q] ? {y_q, 1'b0} : {1'b0, y_q};
  end

  // final placement of the mantissa
  logic [95:0] wide;
  logic [5:0]  sl, sr;
  logic signed [39:0] qd;
  always_comb begin
    qd   = qi_q - 40'sd31;
    sl   = qd[5:0];
    sr   = 6'(-qd);
    wide = {64'd0, y_q} << sl;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      escu_pkg::ST_IDLE:   if (start_i) state_d = escu_pkg::ST_BLO;
      escu_pkg::ST_BLO:    state_d = escu_pkg::ST_BHI;
      escu_pkg::ST_BHI:    state_d = escu_pkg::ST_BFIN;
      escu_pkg::ST_BFIN: begin
        if (act_q || (h_q == 64'd0) || (cfg_i.safety == 32'd0)) state_d = escu_pkg::ST_DONE;
        else state_d = escu_pkg::ST_LLOAD;
      end
      escu_pkg::ST_LLOAD:  state_d = escu_pkg::ST_LNORM;
      escu_pkg::ST_LNORM:  if (cnt_q == 6'd5) state_d = escu_pkg::ST_LSQ;
      escu_pkg::ST_LSQ:    state_d = escu_pkg::ST_LSQR;
      escu_pkg::ST_LSQR: begin
        if (cnt_q == 6'(escu_pkg::LogFrac - 1)) state_d = escu_pkg::ST_LEND;
        else state_d = escu_pkg::ST_LSQ;
      end
      escu_pkg::ST_LEND: begin
        if (lsel_q != 2'd3) state_d = escu_pkg::ST_LLOAD;
        else if (first_q) state_d = escu_pkg::ST_DIV;
        else state_d = escu_pkg::ST_G1;
      end
      escu_pkg::ST_G1:     state_d = escu_pkg::ST_G2;
      escu_pkg::ST_G2:     state_d = escu_pkg::ST_G3;
      escu_pkg::ST_G3:     state_d = escu_pkg::ST_DIV;
      escu_pkg::ST_DIV:    if (cnt_q == 6'd63) state_d = escu_pkg::ST_ESET;
      escu_pkg::ST_ESET: begin
        if ($signed(esum[63:escu_pkg::LogFrac]) >= 40'sd64) state_d = escu_pkg::ST_DONE;
        else state_d = escu_pkg::ST_SQLOAD;
      end
      escu_pkg::ST_SQLOAD: state_d = escu_pkg::ST_SQRT;
      escu_pkg::ST_SQRT: begin
        if (cnt_q == 6'd31) begin
          if (it_q == 5'(escu_pkg::LogFrac - 1)) state_d = escu_pkg::ST_FIN;
          else state_d = escu_pkg::ST_SQLOAD;
        end
      end
      escu_pkg::ST_FIN:    state_d = escu_pkg::ST_DONE;
      escu_pkg::ST_DONE:   if (ack_i) state_d = escu_pkg::ST_IDLE;
      default:             state_d = escu_pkg::ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    cnt_d = cnt_q; it_d = it_q; lsel_d = lsel_q;
    act_d = act_q; first_d = first_q; h_d = h_q; dsm_d = dsm_q; prev_d = prev_q;
    ecur_d = ecur_q; lo_d = lo_q; x_d = x_q; n_d = n_q; y_d = y_q; frac_d = frac_q;
    l1_d = l1_q; lp_d = lp_q; lh_d = lh_q; ls_d = ls_q; g_d = g_q;
    dv_d = dv_q; rem_d = rem_q; neg_d = neg_q; qi_d = qi_q;
    sx_d = sx_q; sres_d = sres_q; sbit_d = sbit_q; rv_d = rv_q; sat_d = sat_q;
    unique case (state_q)
      escu_pkg::ST_IDLE: begin
        act_d = action_i; h_d = step_size_i; dsm_d = error_norm_i;
        prev_d = prev_error_i; first_d = first_step_i;
      end
      escu_pkg::ST_BHI: lo_d = mul_p[63:0];
      escu_pkg::ST_BFIN: begin
        ecur_d = bias_val;
        lsel_d = 2'd0;
        rv_d   = '0;
        sat_d  = 1'b0;
      end
      escu_pkg::ST_LLOAD: begin
        x_d = lop; n_d = 6'd63; cnt_d = '0;
      end
      escu_pkg::ST_LNORM: begin
        x_d = x_nrm; n_d = n_nrm;
        if (cnt_q == 6'd5) begin
          y_d = x_nrm[63:32]; cnt_d = '0; frac_d = '0;
        end else cnt_d = cnt_q + 6'd1;
      end
      escu_pkg::ST_LSQR: begin
        if (mul_p[63]) begin
          y_d = mul_p[63:32]; frac_d = {frac_q[22:0], 1'b1};
        end else begin
          y_d = mul_p[62:31]; frac_d = {frac_q[22:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
      end
      escu_pkg::ST_LEND: begin
        case (lsel_q)
          2'd0:    l1_d = lv - $signed(DOff);
          2'd1:    lp_d = lv - $signed(DOff);
          2'd2:    lh_d = lv;
          default: ls_d = lv;
        endcase
        lsel_d = (lsel_q == 2'd0 && first_q) ? 2'd2 : lsel_q + 2'd1;
        // first step: dividend is minus the current error log
        neg_d = !l1_q[31] && (l1_q != 32'sd0);
        dv_d  = {32'd0, mag1};
        rem_d = '0;
        cnt_d = '0;
      end
      escu_pkg::ST_G2: g_d = gs;
      escu_pkg::ST_G3: begin
        neg_d = !gsum[63] && (gsum != 64'sd0);
        dv_d  = gsum[63] ? 64'(-gsum) : 64'(gsum);
        rem_d = '0;
        cnt_d = '0;
      end
      escu_pkg::ST_DIV: begin
        rem_d = qbit ? 4'(r5 - {1'b0, order}) : r5[3:0];
        dv_d  = {dv_q[62:0], qbit};
        cnt_d = cnt_q + 6'd1;
      end
      escu_pkg::ST_ESET: begin
        qi_d   = esum[63:escu_pkg::LogFrac];
        frac_d = esum[escu_pkg::LogFrac-1:0];
        y_d    = 32'h8000_0000;
        it_d   = '0;
        if ($signed(esum[63:escu_pkg::LogFrac]) >= 40'sd64) begin
          rv_d = '1; sat_d = 1'b1;
        end
      end
      escu_pkg::ST_SQLOAD: begin
        sx_d = {sv, 31'd0}; sres_d = '0; sbit_d = 64'd1 << 62; cnt_d = '0;
      end
      escu_pkg::ST_SQRT: begin
        if (sge) begin
          sx_d = sx_q - st; sres_d = (sres_q >> 1) + sbit_q;
        end else sres_d = sres_q >> 1;
        sbit_d = sbit_q >> 2;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          y_d  = sge ? 32'((sres_q >> 1) + sbit_q) : 32'(sres_q >> 1);
          it_d = it_q + 5'd1;
        end
      end
      escu_pkg::ST_FIN: begin
        if (qi_q >= 40'sd31) begin
          if (wide[95:64] != 32'd0) begin
            rv_d = '1; sat_d = 1'b1;
          end else rv_d = wide[63:0];
        end else if (qi_q <= -40'sd33) rv_d = '0;
        else rv_d = {32'd0, y_q} >> sr;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= escu_pkg::ST_IDLE;
      cnt_q   <= '0;
      it_q    <= '0;
      lsel_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      it_q    <= it_d;
      lsel_q  <= lsel_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d; first_q <= first_d; h_q <= h_d; dsm_q <= dsm_d; prev_q <= prev_d;
    ecur_q <= ecur_d; lo_q <= lo_d; x_q <= x_d; n_q <= n_d; y_q <= y_d; frac_q <= frac_d;
    l1_q <= l1_d; lp_q <= lp_d; lh_q <= lh_d; ls_q <= ls_d; g_q <= g_d;
    dv_q <= dv_d; rem_q <= rem_d; neg_q <= neg_d; qi_q <= qi_d;
    sx_q <= sx_d; sres_q <= sres_d; sbit_q <= sbit_d; rv_q <= rv_d; sat_q <= sat_d;
  end

  // status out
  always_comb begin
    res_o.idle   = (state_q == escu_pkg::ST_IDLE);
    res_o.done   = (state_q == escu_pkg::ST_DONE);
    res_o.record = act_q;
    res_o.value  = rv_q;
    res_o.sat    = sat_q;
    res_o.ecur   = ecur_q;
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == escu_pkg::ST_IDLE) else $error("start while busy");
  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == escu_pkg::ST_LNORM |-> x_q != 64'd0) else $error("log of zero");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == escu_pkg::ST_DIV |-> rem_q < order) else $error("remainder range");
`endif

endmodule

// ===== src/explicit_step_size_controller_unit.sv =====
// ----------------------------------------------------------------------------
// explicit_step_size_controller_unit: adaptive ODE step-size controller
// Proposes a new step from step size and error norm; records accepted errors.
// ----------------------------------------------------------------------------
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | action_i, step_size_i, error_norm_i
// out     | output    | out_valid_o / out_ready_i | new_step_size_o, saturated_o
// cfg     | input     | cfg_we_i                  | cfg_addr_i, cfg_wdata_i
//
// A record request, like an estimate with zero step or safety, ends once the
// biased error is formed. An estimate otherwise runs three log2 runs (four
// after the first step), an order divide and, unless the exponent saturates,
// 24 square roots, all on one sequencer with a shared multiplier.
// in_ready_o is high only while the sequencer is idle; a finished estimate
// holds the sequencer until the output register is empty or being read out.
// Reset restores the register defaults, prev_error = 1.0 and the first-step flag.
// ----------------------------------------------------------------------------
module explicit_step_size_controller_unit #(
  parameter int unsigned DATA_FRAC_BITS = 40,
  parameter int unsigned GAIN_FRAC_BITS = 28,
  parameter int unsigned TINY_FLOOR     = 110
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [63:0] step_size_i,
  input  logic [63:0] error_norm_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] new_step_size_o,
  output logic        saturated_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  escu_pkg::cfg_t cfg_q, cfg_d;
  escu_pkg::res_t res;
  logic [63:0] prev_q, prev_d;
  logic        first_q, first_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_val_q;
  logic        out_sat_q;
  logic        start, ack;

  assign in_ready_o = res.idle;
  assign start      = in_valid_i && res.idle;
  assign ack        = res.done && (res.record || !out_valid_q || out_ready_i);

  escu_core #(
    .DATA_FRAC_BITS (DATA_FRAC_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .TINY_FLOOR     (TINY_FLOOR)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .action_i     (action_i),
    .step_size_i  (step_size_i),
    .error_norm_i (error_norm_i),
    .prev_error_i (prev_q),
    .first_step_i (first_q),
    .cfg_i        (cfg_q),
    .ack_i        (ack),
    .res_o        (res)
  );

  // configuration decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        escu_pkg::REG_GAIN_CUR: cfg_d.gain_cur = cfg_wdata_i;
        escu_pkg::REG_GAIN_RAT: cfg_d.gain_rat = cfg_wdata_i;
        escu_pkg::REG_BIAS:     cfg_d.bias     = cfg_wdata_i;
        escu_pkg::REG_SAFETY:   cfg_d.safety   = cfg_wdata_i;
        escu_pkg::REG_ORDER:    cfg_d.order    = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // controller state and output slot
  always_comb begin
    prev_d      = prev_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (ack && res.record) begin
      prev_d  = res.ecur;
      first_d = 1'b0;
    end
    if (ack && !res.record) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_cur <= 32'd98515812;
      cfg_q.gain_rat <= 32'd71940702;
      cfg_q.bias     <= 32'd402653184;
      cfg_q.safety   <= 32'd257698038;
      cfg_q.order    <= 4'd1;
      prev_q         <= 64'd1 << DATA_FRAC_BITS;
      first_q        <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      prev_q      <= prev_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ack && !res.record) begin
      out_val_q <= res.value;
      out_sat_q <= res.sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_step_size_o = out_val_q;
  assign saturated_o     = out_sat_q;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Step-size controller testbench
// Drives estimate and record requests with random idling on both channels,
// predicts every proposed step in the log2 domain and checks each response.
// Register settings change between phases, with extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DataFrac = 40;
  localparam int unsigned GainFrac = 28;
  localparam longint unsigned TinyFloor = 110;
  localparam longint LogOne = longint'(1) << escu_pkg::LogFrac;
  localparam longint unsigned LogMask = longint'(LogOne) - 1;
  localparam bit ActEstimate = 1'b0;
  localparam bit ActRecord = 1'b1;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCycles = 2000;

  typedef struct packed {
    logic        action;
    logic [63:0] step_size;
    logic [63:0] error_norm;
  } step_req_t;

  typedef struct packed {
    logic [63:0] new_step;
    logic        sat;
  } step_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = 1'b0;
  logic [63:0] step_size_i = '0;
  logic [63:0] error_norm_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] new_step_size_o;
  logic        saturated_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  explicit_step_size_controller_unit DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] k_cur, k_rat, bias_q, safety_q;
  logic [3:0]  order_q;
  logic [63:0] prev_err;
  bit          first_flag;

  step_req_t pending_reqs[$];
  step_rsp_t expected_steps[$];
  int unsigned n_errors = 0, n_estimates = 0, n_records = 0, n_sat = 0;
  bit  quiet_tail = 1'b0;
  bit  timed_out = 1'b0;

  function automatic logic [63:0] bias_mul(logic [63:0] d, logic [31:0] b);
    logic [95:0] prod;
    prod = ({32'd0, d} * {64'd0, b}) >> GainFrac;
    return (prod[95:64] != 0) ? '1 : prod[63:0];
  endfunction

  function automatic longint log2_fix(logic [63:0] x);
    int n;
    logic [63:0] y;
    longint unsigned frac;
    n = 63;
    frac = 0;
    while (n > 0 && !x[n]) n--;
    y = (x << (63 - n)) >> 32;
    for (int i = 0; i < escu_pkg::LogFrac; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y[63:32] != 0) begin
        frac |= 1;
        y = y >> 1;
      end
    end
    return longint'(n) * LogOne + longint'(frac);
  endfunction

  function automatic longint scale_by_gain(longint v, logic [31:0] k);
    logic [63:0] mag;
    logic [95:0] p;
    mag = (v < 0) ? -v : v;
    p = ({32'd0, mag} * {64'd0, k}) >> GainFrac;
    return (v < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic step_rsp_t exp2_fix(longint e);
    longint q;
    logic [63:0] f, y, v, m;
    int s;
    step_rsp_t r;
    r = '0;
    y = 64'd1 << 31;
    if (e >= 0) q = e >>> escu_pkg::LogFrac;
    else begin
      m = -e;
      q = -longint'((m + LogMask) >> escu_pkg::LogFrac);
    end
    f = (e - q * LogOne) & LogMask;
    if (q >= 64) return '{'1, 1'b1};
    for (int i = 0; i < escu_pkg::LogFrac; i++) begin
      v = f[i] ? (y << 1) : y;
      y = int_sqrt(v << 31);
    end
    if (q >= 31) begin
      s = int'(q - 31);
      if (s == 0) r.new_step = y;
      else if ((y >> (64 - s)) != 0) r = '{'1, 1'b1};
      else r.new_step = y << s;
    end else begin
      if (31 - q >= 64) r.new_step = 0;
      else r.new_step = y >> (31 - q);
    end
    return r;
  endfunction

  // apply one request to the predictor, queue the expected proposal
  function automatic void predict_step(step_req_t rq);
    logic [63:0] ecur, e1, ep;
    longint p, l1, lp, x, e;
    step_rsp_t r;
    ecur = bias_mul(rq.error_norm, bias_q);
    p = (order_q == 0) ? 1 : longint'(order_q);
    if (rq.action == ActRecord) begin
      prev_err = ecur;
      first_flag = 1'b0;
      n_records++;
      return;
    end
    n_estimates++;
    if (rq.step_size == 0 || safety_q == 0) begin
      expected_steps.push_back('0);
      return;
    end
    e1 = (ecur > TinyFloor) ? ecur : TinyFloor;
    l1 = log2_fix(e1) - longint'(DataFrac) * LogOne;
    if (first_flag) x = -l1 / p;
    else begin
      ep = (prev_err > TinyFloor) ? prev_err : TinyFloor;
      lp = log2_fix(ep) - longint'(DataFrac) * LogOne;
      x = -(scale_by_gain(l1, k_cur) + scale_by_gain(l1 - lp, k_rat)) / p;
    end
    e = log2_fix(rq.step_size) + log2_fix({32'd0, safety_q})
        - longint'(GainFrac) * LogOne + x;
    r = exp2_fix(e);
    if (r.sat) n_sat++;
    expected_steps.push_back(r);
  endfunction

  // request driver
  int unsigned src_gap = 0;
  always @(posedge clk_i) begin
    step_req_t nx;
    if (in_valid_i && in_ready_o) predict_step(pending_reqs.pop_front());
    if (in_valid_i && !in_ready_o) begin
      // hold until accepted
    end else if (src_gap != 0) begin
      src_gap <= src_gap - 1;
      in_valid_i <= 1'b0;
    end else if ((in_valid_i && in_ready_o ? pending_reqs.size() : pending_reqs.size()) != 0
                 && !quiet_tail && $urandom_range(7) == 0) begin
      src_gap <= $urandom_range(16, 1) - 1;
      in_valid_i <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      nx = pending_reqs[0];
      in_valid_i <= 1'b1;
      action_i <= nx.action;
      step_size_i <= nx.step_size;
      error_norm_i <= nx.error_norm;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // response monitor with receiver stalls
  int unsigned sink_gap = 0;
  always @(posedge clk_i) begin
    step_rsp_t ex;
    if (out_valid_o && out_ready_i) begin
      if (expected_steps.size() == 0) begin
        $error("unexpected response: new_step_size %h", new_step_size_o);
        n_errors++;
      end else begin
        ex = expected_steps.pop_front();
        if (new_step_size_o !== ex.new_step) begin
          $error("new_step_size: expected %h, actual %h", ex.new_step, new_step_size_o);
          n_errors++;
        end
        if (saturated_o !== ex.sat) begin
          $error("saturated: expected %b, actual %b", ex.sat, saturated_o);
          n_errors++;
        end
      end
    end
    if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet_tail && $urandom_range(5) == 0) begin
      sink_gap <= $urandom_range(16, 1) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  int unsigned stall_count = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(escu_pkg::reg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      escu_pkg::REG_GAIN_CUR: k_cur = val;
      escu_pkg::REG_GAIN_RAT: k_rat = val;
      escu_pkg::REG_BIAS:     bias_q = val;
      escu_pkg::REG_SAFETY:   safety_q = val;
      escu_pkg::REG_ORDER:    order_q = val[3:0];
      default: ;
    endcase
  endtask

  // wait for the block to drain, then let a record request finish
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_steps.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // values spread across all magnitudes
  function automatic logic [63:0] rand_mag();
    logic [63:0] v;
    v = rand64();
    return (v >> $urandom_range(63)) | 64'(v[0]);
  endfunction

  function automatic void add_req(bit act, logic [63:0] h, logic [63:0] en);
    pending_reqs.push_back('{act, h, en});
  endfunction

  // mostly small exponents near 1.0; occasionally wild
  function automatic void add_random_batch(int unsigned count);
    logic [63:0] h, en;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        h = rand_mag();
        en = rand_mag();
      end else begin
        h = (64'd1 << DataFrac) >> $urandom_range(20);
        h = h ^ (rand64() >> $urandom_range(63, 24));
        en = (64'd1 << DataFrac) >> $urandom_range(12);
        en = en ^ (rand64() >> $urandom_range(63, 30));
      end
      if ($urandom_range(15) == 0) h = 0;
      if ($urandom_range(40) == 0) h = '1;
      if ($urandom_range(40) == 0) en = '1;
      add_req($urandom_range(2) == 0 ? ActRecord : ActEstimate, h, en);
    end
  endfunction

  initial begin
    logic [63:0] one;
    one = 64'd1 << DataFrac;
    k_cur = 32'd98515812;
    k_rat = 32'd71940702;
    bias_q = 32'd402653184;
    safety_q = 32'd257698038;
    order_q = 4'd1;
    prev_err = one;
    first_flag = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first-step behavior, extremes, zero step, saturation
    add_req(ActEstimate, one, one);
    add_req(ActEstimate, 0, one);
    add_req(ActEstimate, '1, 0);
    add_req(ActEstimate, '1, '1);
    add_req(ActEstimate, 64'd1, '1);
    add_req(ActEstimate, one, 64'd1);
    add_req(ActRecord, '1, '1);
    add_req(ActEstimate, one, one);
    add_req(ActRecord, 0, 0);
    add_req(ActEstimate, one, 0);
    add_req(ActEstimate, '1, 64'd1);
    add_req(ActRecord, 0, one);
    add_req(ActEstimate, one >> 10, one >> 3);
    drain();

    // zero safety, order zero and max order, max gains
    write_reg(escu_pkg::REG_SAFETY, 32'd0);
    write_reg(escu_pkg::REG_ORDER, 32'd0);
    add_req(ActEstimate, one, one);
    add_req(ActEstimate, '1, 64'd5);
    drain();
    write_reg(escu_pkg::REG_SAFETY, '1);
    write_reg(escu_pkg::REG_GAIN_CUR, '1);
    write_reg(escu_pkg::REG_GAIN_RAT, '1);
    write_reg(escu_pkg::REG_BIAS, '1);
    add_req(ActEstimate, '1, '1);
    add_req(ActEstimate, one, 64'd1);
    add_req(ActRecord, 0, 64'd1);
    add_req(ActEstimate, one, '1);
    drain();
    write_reg(escu_pkg::REG_ORDER, 32'd15);
    write_reg(escu_pkg::REG_BIAS, 32'd0);
    add_req(ActEstimate, one, one);
    add_req(ActRecord, 0, one);
    add_req(ActEstimate, one, one);
    drain();

    // random phases over a spread of settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(escu_pkg::REG_GAIN_CUR,
                ph == 5 ? 32'd0 : $urandom_range(32'h3000_0000));
      write_reg(escu_pkg::REG_GAIN_RAT,
                ph == 5 ? 32'd0 : $urandom_range(32'h3000_0000));
      write_reg(escu_pkg::REG_BIAS,
                ph == 4 ? $urandom : $urandom_range(32'h2000_0000, 32'h0100_0000));
      write_reg(escu_pkg::REG_SAFETY, $urandom_range(32'h1800_0000, 32'h0800_0000));
      write_reg(escu_pkg::REG_ORDER, ph == 3 ? 32'd15 : $urandom_range(5, 1));
      if (ph == 5) quiet_tail = 1'b1;
      add_random_batch(240);
      drain();
    end

    $display("covered %0d estimates (%0d saturated) and %0d records over 10 settings",
             n_estimates, n_sat, n_records);
    if (n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== explicit_step_size_controller_unit.f =====
src/escu_pkg.sv
src/escu_mul.sv
src/escu_core.sv
src/explicit_step_size_controller_unit.sv
test/testbench.sv
